// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/qbm_pkg.sv
// ----------------------------------------------------------------------------
// qbm_pkg
// types, constants and helpers of the quadrilateral bilinear mapper
// ----------------------------------------------------------------------------
package qbm_pkg;

	localparam int SHEET_WIDTH  = 256;
	localparam int SHEET_HEIGHT = 256;

	localparam logic [11:0] SHEET_W_LIM = 12'(SHEET_WIDTH);
	localparam logic [11:0] SHEET_H_LIM = 12'(SHEET_HEIGHT);

	// round(2^32 / size)
	localparam logic [32:0] RECIP_W =
		33'((64'd4294967296 + 64'(SHEET_WIDTH) / 64'd2) / 64'(SHEET_WIDTH));
	localparam logic [32:0] RECIP_H =
		33'((64'd4294967296 + 64'(SHEET_HEIGHT) / 64'd2) / 64'(SHEET_HEIGHT));

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef enum logic [3:0] {
		REG_TOP_LEFT_X     = 4'd0,
		REG_TOP_LEFT_Y     = 4'd1,
		REG_TOP_RIGHT_X    = 4'd2,
		REG_TOP_RIGHT_Y    = 4'd3,
		REG_BOTTOM_RIGHT_X = 4'd4,
		REG_BOTTOM_RIGHT_Y = 4'd5,
		REG_BOTTOM_LEFT_X  = 4'd6,
		REG_BOTTOM_LEFT_Y  = 4'd7
	} reg_idx_t;

	// corner coordinates of one axis
	typedef struct packed {
		logic [9:0] tl;
		logic [9:0] tr;
		logic [9:0] br;
		logic [9:0] bl;
	} corner_t;

	// clamp, scale by reciprocal, round and cap to 1.0 in Q1.16
	function automatic logic [16:0] normalise(logic [11:0] pos, logic [11:0] limit,
		logic [32:0] recip);
		logic [11:0] p;
		logic [44:0] prod;
		logic [28:0] q;
		p = (pos > limit) ? limit : pos;
		prod = 45'(p) * 45'(recip);
		q = 29'((prod + 45'd32768) >> 16);
		return (q > 29'(ONE_Q16)) ? ONE_Q16 : q[16:0];
	endfunction

endpackage

// File: rtl/core/quad_bilinear_map.sv
// ----------------------------------------------------------------------------
// quad_bilinear_map
// maps a sheet position to camera pixels by bilinear corner interpolation
// ----------------------------------------------------------------------------
// Usage:
//   Load the four corner points over the cfg channel (cfg_index 0..7, 10-bit
//   cfg_data) while no item is in flight; cfg_ready is always high and
//   indexes beyond 7 are ignored.
//   Send sheet_x/sheet_y on the in channel; one cam_x/cam_y item comes out
//   on the out channel for each, in order, as unsigned 10.4 pixels.
//   One item is taken every cycle unless the receiver stalls; the rate is
//   set by the four-stage pipeline (normalise, edge interpolation,
//   vertical blend, rounding), whose stages all advance together.
//   When the receiver stalls (out_ready low with out_valid high) the whole
//   pipeline holds and in_ready drops, so no item is lost or repeated;
//   empty stages hold as well until the output item is taken.
//   Reset clears all corner registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module quad_bilinear_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] sheet_x,
	input  logic [11:0] sheet_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [13:0] cam_x,
	output logic [13:0] cam_y
);
	import qbm_pkg::*;

	`include "assert_macros.svh"

	corner_t     crn_x_q;
	corner_t     crn_y_q;
	logic        adv;
	logic        vld_s1;
	logic        vld_s2;
	logic        vld_s3;
	logic        vld_s4;
	logic [16:0] u_s1;
	logic [16:0] v_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crn_x_q <= '0;
			crn_y_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TOP_LEFT_X:     crn_x_q.tl <= cfg_data;
				REG_TOP_LEFT_Y:     crn_y_q.tl <= cfg_data;
				REG_TOP_RIGHT_X:    crn_x_q.tr <= cfg_data;
				REG_TOP_RIGHT_Y:    crn_y_q.tr <= cfg_data;
				REG_BOTTOM_RIGHT_X: crn_x_q.br <= cfg_data;
				REG_BOTTOM_RIGHT_Y: crn_y_q.br <= cfg_data;
				REG_BOTTOM_LEFT_X:  crn_x_q.bl <= cfg_data;
				REG_BOTTOM_LEFT_Y:  crn_y_q.bl <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv       = !vld_s4 || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: clamp and normalise to Q1.16
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= normalise(sheet_x, SHEET_W_LIM, RECIP_W);
			v_s1 <= normalise(sheet_y, SHEET_H_LIM, RECIP_H);
		end
	end

	qbm_axis u_axis_x (
		.clk    (clk),
		.en     (adv),
		.u_s1   (u_s1),
		.v_s1   (v_s1),
		.crn    (crn_x_q),
		.res_s4 (cam_x)
	);

	qbm_axis u_axis_y (
		.clk    (clk),
		.en     (adv),
		.u_s1   (u_s1),
		.v_s1   (v_s1),
		.crn    (crn_y_q),
		.res_s4 (cam_y)
	);

	`ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, vld_s1)
	`ASSERT_NEXT(a_s3_reaches_out, vld_s3 && adv, out_valid)
	`ASSERT_NEXT(a_stall_holds_pipe, !adv,
		vld_s1 == $past(vld_s1) && vld_s2 == $past(vld_s2) && vld_s3 == $past(vld_s3))
	`ASSERT_IMPLIES(a_norm_capped, vld_s1, u_s1 <= ONE_Q16 && v_s1 <= ONE_Q16)

endmodule

// File: rtl/core/qbm_axis.sv
// ----------------------------------------------------------------------------
// qbm_axis
// edge interpolation, vertical blend and rounding for one camera axis
// ----------------------------------------------------------------------------
module qbm_axis (
	input  logic             clk,
	input  logic             en,
	input  logic [16:0]      u_s1,
	input  logic [16:0]      v_s1,
	input  qbm_pkg::corner_t crn,
	output logic [13:0]      res_s4
);
	import qbm_pkg::*;

	logic [25:0] near_s2;
	logic [25:0] far_s2;
	logic [16:0] v_s2;
	logic [41:0] blend_s3;

	logic signed [10:0] near_diff;
	logic signed [10:0] far_diff;
	logic signed [28:0] near_sum;
	logic signed [28:0] far_sum;
	logic signed [26:0] edge_diff;
	logic signed [44:0] blend_sum;
	logic [41:0] round_sum;

	// stage 2: bottom and top edges along u
	always_comb begin
		near_diff = $signed({1'b0, crn.br}) - $signed({1'b0, crn.bl});
		far_diff  = $signed({1'b0, crn.tr}) - $signed({1'b0, crn.tl});
		near_sum  = $signed({3'b000, crn.bl, 16'h0000}) + $signed({1'b0, u_s1}) * near_diff;
		far_sum   = $signed({3'b000, crn.tl, 16'h0000}) + $signed({1'b0, u_s1}) * far_diff;
	end

	// stage 3: blend between edges along v
	always_comb begin
		edge_diff = $signed({1'b0, far_s2}) - $signed({1'b0, near_s2});
		blend_sum = $signed({3'b000, near_s2, 16'h0000}) + $signed({1'b0, v_s2}) * edge_diff;
	end

	// stage 4: round half up to 4 fraction bits
	assign round_sum = blend_s3 + 42'h000_0800_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			near_s2  <= near_sum[25:0];
			far_s2   <= far_sum[25:0];
			v_s2     <= v_s1;
			blend_s3 <= blend_sum[41:0];
			res_s4   <= round_sum[41:28];
		end
	end

endmodule

// File: dv/qbm_checker.sv
// ----------------------------------------------------------------------------
// qbm_checker
// watches the ports of quad_bilinear_map and checks every camera point
// ----------------------------------------------------------------------------
// Tracks the corner registers from accepted writes, and computes the camera
// point for each accepted sheet point: clamp to the sheet, normalise to
// Q1.16, interpolate along both edges, blend, round to 10.4. Each accepted
// result is compared with the oldest prediction. Reports the number of
// failures and the number of points still in flight.
// ----------------------------------------------------------------------------
module qbm_checker
	import qbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [11:0] sheet_x,
	input  logic [11:0] sheet_y,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [13:0] cam_x,
	input  logic [13:0] cam_y,
	output int          fail_count,
	output int          outstanding
);

	localparam int NUM_CORNER_REGS = int'(REG_BOTTOM_LEFT_Y) + 1;

	typedef struct packed {
		logic [13:0] x;
		logic [13:0] y;
	} cam_point_t;

	logic [9:0] corner [NUM_CORNER_REGS];
	cam_point_t expected_cam [$];

	// sheet position to Q1.16 fraction, clamped and capped at 1.0
	function automatic logic [16:0] sheet_frac(logic [11:0] pos, int unsigned size);
		longint unsigned recip;
		longint unsigned p;
		longint unsigned q;
		recip = ((64'd1 << 32) + 64'(size / 2)) / 64'(size);
		p = (pos > size) ? 64'(size) : 64'(pos);
		q = (p * recip + 64'h8000) >> 16;
		return (q > 64'(ONE_Q16)) ? ONE_Q16 : 17'(q);
	endfunction

	// bilinear blend of one axis, rounded to 10.4 pixels
	function automatic logic [13:0] blend_axis(logic [16:0] u, logic [16:0] v,
		logic [9:0] bl, logic [9:0] br, logic [9:0] tl, logic [9:0] tr);
		longint unsigned one;
		longint unsigned uu;
		longint unsigned vv;
		longint unsigned near_e;
		longint unsigned far_e;
		longint unsigned acc;
		one = 64'(ONE_Q16);
		uu = 64'(u);
		vv = 64'(v);
		near_e = (one - uu) * 64'(bl) + uu * 64'(br);
		far_e = (one - uu) * 64'(tl) + uu * 64'(tr);
		acc = (one - vv) * near_e + vv * far_e;
		return 14'((acc + (64'd1 << 27)) >> 28);
	endfunction

	function automatic cam_point_t sheet_to_cam(logic [11:0] x, logic [11:0] y);
		cam_point_t pt;
		logic [16:0] u;
		logic [16:0] v;
		u = sheet_frac(x, SHEET_WIDTH);
		v = sheet_frac(y, SHEET_HEIGHT);
		pt.x = blend_axis(u, v, corner[REG_BOTTOM_LEFT_X], corner[REG_BOTTOM_RIGHT_X],
			corner[REG_TOP_LEFT_X], corner[REG_TOP_RIGHT_X]);
		pt.y = blend_axis(u, v, corner[REG_BOTTOM_LEFT_Y], corner[REG_BOTTOM_RIGHT_Y],
			corner[REG_TOP_LEFT_Y], corner[REG_TOP_RIGHT_Y]);
		return pt;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		cam_point_t want;
		int bad;
		bad = 0;
		if (!arst_n) begin
			foreach (corner[i])
				corner[i] = '0;
			expected_cam.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index <= REG_BOTTOM_LEFT_Y)
				corner[cfg_index[2:0]] = cfg_data;
			if (in_valid && in_ready)
				expected_cam.push_back(sheet_to_cam(sheet_x, sheet_y));
			if (out_valid && out_ready) begin
				if (expected_cam.size() == 0) begin
					$error("unexpected item: cam_x %0d cam_y %0d", cam_x, cam_y);
					bad++;
				end else begin
					want = expected_cam.pop_front();
					if (cam_x !== want.x) begin
						$error("cam_x mismatch: expected %0d, actual %0d", want.x, cam_x);
						bad++;
					end
					if (cam_y !== want.y) begin
						$error("cam_y mismatch: expected %0d, actual %0d", want.y, cam_y);
						bad++;
					end
				end
			end
			outstanding <= expected_cam.size();
			fail_count <= fail_count + bad;
		end
	end

endmodule

// File: dv/tb_quad_bilinear_map.sv
// ----------------------------------------------------------------------------
// tb_quad_bilinear_map
// stimulus and verdict for the quadrilateral bilinear mapper
// ----------------------------------------------------------------------------
// Loads several corner sets (zero, full scale, mixed extremes, random) and
// sends sheet points: first corners, edges, clamped and odd bit patterns,
// then random points mostly on the sheet and partly beyond it. Sender idling
// and receiver stalls change from phase to phase. Checking is done by
// qbm_checker beside the block.
// ----------------------------------------------------------------------------
module tb_quad_bilinear_map;
	import qbm_pkg::*;

	typedef enum int {
		CORNERS_RANDOM,
		CORNERS_ZERO,
		CORNERS_MAX,
		CORNERS_EXTREMES
	} corner_plan_t;

	localparam int NUM_DIRECTED = 14;
	localparam int PHASE_ITEMS  = 250;
	localparam int NUM_PHASES   = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [9:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [11:0] sheet_x = '0;
	logic [11:0] sheet_y = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [13:0] cam_x;
	logic [13:0] cam_y;
	int          fail_count;
	int          outstanding;
	int          send_idle_pct = 0;
	int          stall_pct = 0;

	logic [11:0] dir_x [NUM_DIRECTED] = '{12'd0, SHEET_W_LIM, 12'd0, SHEET_W_LIM,
		SHEET_W_LIM / 12'd2, 12'd1, SHEET_W_LIM - 12'd1, SHEET_W_LIM + 12'd1, 12'd0,
		12'hFFF, 12'hAAA, 12'h555, 12'hFFF, 12'h800};
	logic [11:0] dir_y [NUM_DIRECTED] = '{12'd0, 12'd0, SHEET_H_LIM, SHEET_H_LIM,
		SHEET_H_LIM / 12'd2, 12'd1, SHEET_H_LIM - 12'd1, 12'd0, SHEET_H_LIM + 12'd1,
		12'hFFF, 12'h555, 12'hAAA, 12'd0, 12'd1};

	quad_bilinear_map u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sheet_x   (sheet_x),
		.sheet_y   (sheet_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cam_x     (cam_x),
		.cam_y     (cam_y)
	);

	qbm_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sheet_x     (sheet_x),
		.sheet_y     (sheet_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cam_x       (cam_x),
		.cam_y       (cam_y),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_point(input logic [11:0] x, input logic [11:0] y);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sheet_x <= x;
		sheet_y <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [9:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for every item to come out
	task automatic settle();
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_corners(input corner_plan_t plan);
		logic [9:0] val;
		for (int i = 0; i <= int'(REG_BOTTOM_LEFT_Y); i++) begin
			case (plan)
				CORNERS_ZERO:     val = '0;
				CORNERS_MAX:      val = '1;
				CORNERS_EXTREMES: val = $urandom_range(1) ? '1 : '0;
				default:          val = 10'($urandom());
			endcase
			write_reg(4'(reg_idx_t'(i)), val);
		end
		// index beyond the last corner, must be ignored
		write_reg(4'($urandom_range(15, int'(REG_BOTTOM_LEFT_Y) + 1)), 10'($urandom()));
	endtask

	initial begin
		logic [11:0] px;
		logic [11:0] py;
		corner_plan_t plan;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corners still at reset value
		send_point(12'd100, 12'd100);
		send_point(12'hFFF, 12'hFFF);
		@(negedge clk);
		in_valid <= 1'b0;
		settle();

		// skewed quad with every corner coordinate at an extreme
		write_reg(REG_TOP_LEFT_X, 10'd0);
		write_reg(REG_TOP_LEFT_Y, 10'd1023);
		write_reg(REG_TOP_RIGHT_X, 10'd1023);
		write_reg(REG_TOP_RIGHT_Y, 10'd1023);
		write_reg(REG_BOTTOM_RIGHT_X, 10'd1023);
		write_reg(REG_BOTTOM_RIGHT_Y, 10'd0);
		write_reg(REG_BOTTOM_LEFT_X, 10'd0);
		write_reg(REG_BOTTOM_LEFT_Y, 10'd0);
		write_reg(4'($urandom_range(15, int'(REG_BOTTOM_LEFT_Y) + 1)), 10'h2AA);
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_point(dir_x[i], dir_y[i]);
		@(negedge clk);
		in_valid <= 1'b0;
		settle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 86;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 86;
				end
				default: begin
					send_idle_pct = 17;
					stall_pct = 17;
				end
			endcase
			case (ph)
				0:       plan = CORNERS_MAX;
				2:       plan = CORNERS_ZERO;
				4:       plan = CORNERS_EXTREMES;
				default: plan = CORNERS_RANDOM;
			endcase
			load_corners(plan);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// halfway through phase 1, hold off until the pipeline is empty
				if (ph == 1 && i == PHASE_ITEMS / 2) begin
					@(negedge clk);
					in_valid <= 1'b0;
					do @(posedge clk); while (outstanding != 0);
				end
				if ($urandom_range(3) != 0) begin
					px = 12'($urandom_range(SHEET_WIDTH));
					py = 12'($urandom_range(SHEET_HEIGHT));
				end else begin
					px = 12'($urandom());
					py = 12'($urandom());
				end
				send_point(px, py);
			end
			@(negedge clk);
			in_valid <= 1'b0;
			settle();
		end

		if (fail_count == 0 && outstanding == 0) begin
			$display("** quad_bilinear_map: PASSED **");
		end else begin
			$display("** quad_bilinear_map: FAILED **");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("** quad_bilinear_map: FAILED **");
		$finish;
	end

endmodule
